// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assertion helper macros used by the deque unit
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds on every clock edge out of reset
`define CHECK_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define CHECK_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define CHECK_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/odq_pkg.sv =====
// ---------------------------------------------------------------------------
// odq_pkg
// types and constants of the ordered deque with match remove
// ---------------------------------------------------------------------------
package odq_pkg;

   localparam int VALUE_W   = 32;
   localparam int OUT_CNT_W = 5;

   typedef enum logic [1:0] {
      OP_BACK   = 2'd0,
      OP_FRONT  = 2'd1,
      OP_REMOVE = 2'd2,
      OP_FIND   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      CELL_HOLD       = 2'd0,
      CELL_PUSH_BACK  = 2'd1,
      CELL_PUSH_FRONT = 2'd2,
      CELL_ROTATE     = 2'd3
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type cmd;
      logic         keep;   // rotate: re-append the head word at the tail
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      ODQ_IDLE   = 2'd0,
      ODQ_ROTATE = 2'd1,
      ODQ_FINISH = 2'd2
   } state_type;

endpackage

// ===== sv/odq_chan_if.sv =====
// ---------------------------------------------------------------------------
// odq channel interfaces
// valid/ready channels for request and response words
// ---------------------------------------------------------------------------
interface odq_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         opcode;
   logic signed [31:0] value;

   modport source (output valid, output opcode, output value, input ready);
   modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface odq_rsp_if;
   logic       valid;
   logic       ready;
   logic       found;
   logic [4:0] removed_count;
   logic [4:0] occupancy;
   logic       overflow;

   modport source (output valid, output found, output removed_count, output occupancy,
                   output overflow, input ready);
   modport sink   (input valid, input found, input removed_count, input occupancy,
                   input overflow, output ready);
endinterface

// ===== sv/odq_cell.sv =====
// ---------------------------------------------------------------------------
// odq_cell
// one storage cell of the deque chain, exchanges its word with its neighbors
// ---------------------------------------------------------------------------
module odq_cell
   import odq_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cell_ctrl_type       ctrl,
   input  logic [VALUE_W-1:0]  item_value,
   input  logic [VALUE_W-1:0]  head_value,
   input  logic [VALUE_W-1:0]  left_value,
   input  logic                left_valid,
   input  logic [VALUE_W-1:0]  right_value,
   input  logic                right_valid,
   output logic [VALUE_W-1:0]  value_out,
   output logic                valid_out
);

   logic [VALUE_W-1:0] value_ff, value_in;
   logic               valid_ff, valid_in;

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      case (ctrl.cmd)
         CELL_HOLD: begin
         end
         CELL_PUSH_BACK: begin
            // first empty cell takes the word
            if (!valid_ff && left_valid) begin
               value_in = item_value;
               valid_in = 1'b1;
            end
         end
         CELL_PUSH_FRONT: begin
            value_in = left_value;
            valid_in = left_valid;
         end
         CELL_ROTATE: begin
            // pop head, everyone moves left, tail cell takes the head back if kept
            if (valid_ff && !right_valid && ctrl.keep) begin
               value_in = head_value;
               valid_in = 1'b1;
            end else begin
               value_in = right_value;
               valid_in = right_valid;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign value_out = value_ff;
   assign valid_out = valid_ff;

endmodule

// ===== sv/ordered_deque_with_match_remove_unit.sv =====
// ---------------------------------------------------------------------------
// ordered_deque_with_match_remove_unit
// bounded ordered store in a chain of cells: push back/front, remove all equal,
// find; remove and find rotate the whole chain through its head once
// ---------------------------------------------------------------------------
// flow: an insert, or a remove or find on an empty store, goes from idle straight
//   to the finish state; otherwise remove and find pass through the rotate state,
//   one chain rotation step per entry held at accept; from finish the response
//   register loads once empty or read, and no new request is taken until then
// reset: synchronous, clears occupancy, cell valid bits, response valid and the control state
// a response may wait in its output register while the next request is taken
module ordered_deque_with_match_remove_unit
   import odq_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic    clock,
   input  logic    reset,
   odq_req_if.sink   req_chan,
   odq_rsp_if.source rsp_chan
);

`include "assert_macros.svh"

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [VALUE_W-1:0]  cell_value [CAPACITY];
   logic                cell_valid [CAPACITY];
   logic [CAPACITY-1:0] valid_vec;
   cell_ctrl_type       ctrl;

   state_type           state_ff, state_in;
   opcode_type          op_ff, op_in;
   logic [VALUE_W-1:0]  value_ff, value_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    remain_ff, remain_in;
   logic [CNT_W-1:0]    removed_ff, removed_in;
   logic                found_ff, found_in;
   logic                ovf_ff, ovf_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_found_ff, rsp_found_in;
   logic [OUT_CNT_W-1:0] rsp_removed_ff, rsp_removed_in;
   logic [OUT_CNT_W-1:0] rsp_occ_ff, rsp_occ_in;
   logic                rsp_ovf_ff, rsp_ovf_in;

   logic req_accept;
   logic full;
   logic is_insert;
   logic match;
   logic rsp_load;

   assign req_chan.ready = (state_ff == ODQ_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign full           = (count_ff == CNT_W'(CAPACITY));
   assign is_insert      = (opcode_type'(req_chan.opcode) == OP_BACK) ||
                           (opcode_type'(req_chan.opcode) == OP_FRONT);
   assign match          = (cell_value[0] == value_ff);
   assign rsp_load       = (state_ff == ODQ_FINISH) && (!rsp_valid_ff || rsp_chan.ready);

   // cell chain
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [VALUE_W-1:0] left_value, right_value;
      logic               left_valid, right_valid;

      if (i == 0) begin : g_head
         assign left_value = req_chan.value;
         assign left_valid = 1'b1;
      end else begin : g_body
         assign left_value = cell_value[i-1];
         assign left_valid = cell_valid[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_value = '0;
         assign right_valid = 1'b0;
      end else begin : g_inner
         assign right_value = cell_value[i+1];
         assign right_valid = cell_valid[i+1];
      end

      odq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .item_value  (req_chan.value),
         .head_value  (cell_value[0]),
         .left_value  (left_value),
         .left_valid  (left_valid),
         .right_value (right_value),
         .right_valid (right_valid),
         .value_out   (cell_value[i]),
         .valid_out   (cell_valid[i])
      );

      assign valid_vec[i] = cell_valid[i];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ODQ_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff          <= op_in;
      value_ff       <= value_in;
      remain_ff      <= remain_in;
      removed_ff     <= removed_in;
      found_ff       <= found_in;
      ovf_ff         <= ovf_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_occ_ff     <= rsp_occ_in;
      rsp_ovf_ff     <= rsp_ovf_in;
   end

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      value_in   = value_ff;
      count_in   = count_ff;
      remain_in  = remain_ff;
      removed_in = removed_ff;
      found_in   = found_ff;
      ovf_in     = ovf_ff;
      ctrl.cmd   = CELL_HOLD;
      ctrl.keep  = 1'b1;

      case (state_ff)
         ODQ_IDLE: begin
            if (req_accept) begin
               op_in      = opcode_type'(req_chan.opcode);
               value_in   = req_chan.value;
               found_in   = 1'b0;
               removed_in = '0;
               ovf_in     = is_insert && full;
               remain_in  = count_ff;
               if (is_insert) begin
                  state_in = ODQ_FINISH;
                  if (!full) begin
                     count_in = count_ff + CNT_W'(1);
                     if (opcode_type'(req_chan.opcode) == OP_BACK) begin
                        ctrl.cmd = CELL_PUSH_BACK;
                     end else begin
                        ctrl.cmd = CELL_PUSH_FRONT;
                     end
                  end
               end else if (count_ff == '0) begin
                  state_in = ODQ_FINISH;
               end else begin
                  state_in = ODQ_ROTATE;
               end
            end
         end
         ODQ_ROTATE: begin
            ctrl.cmd  = CELL_ROTATE;
            ctrl.keep = !(match && (op_ff == OP_REMOVE));
            remain_in = remain_ff - CNT_W'(1);
            if (match) begin
               if (op_ff == OP_REMOVE) begin
                  removed_in = removed_ff + CNT_W'(1);
                  count_in   = count_ff - CNT_W'(1);
               end else begin
                  found_in = 1'b1;
               end
            end
            if (remain_ff == CNT_W'(1)) begin
               state_in = ODQ_FINISH;
            end
         end
         ODQ_FINISH: begin
            if (rsp_load) begin
               state_in = ODQ_IDLE;
            end
         end
         default: begin
            state_in = ODQ_IDLE;
         end
      endcase
   end

   // response output register
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_found_in   = rsp_found_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_occ_in     = rsp_occ_ff;
      rsp_ovf_in     = rsp_ovf_ff;
      if (rsp_load) begin
         rsp_valid_in   = 1'b1;
         rsp_found_in   = found_ff;
         rsp_removed_in = OUT_CNT_W'(removed_ff);
         rsp_occ_in     = OUT_CNT_W'(count_ff);
         rsp_ovf_in     = ovf_ff;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.found         = rsp_found_ff;
   assign rsp_chan.removed_count = rsp_removed_ff;
   assign rsp_chan.occupancy     = rsp_occ_ff;
   assign rsp_chan.overflow      = rsp_ovf_ff;

   `CHECK_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(CAPACITY), "occupancy above capacity")
   `CHECK_IMPLY(a_idle_cells, clock, reset, state_ff == ODQ_IDLE, $countones(valid_vec) == int'(count_ff), "cell valid bits disagree with occupancy")
   `CHECK_IMPLY(a_rotate_remain, clock, reset, state_ff == ODQ_ROTATE, remain_ff != '0, "rotation running with nothing left")
   `CHECK_NEXT(a_insert_full, clock, reset, req_accept && is_insert && full, ovf_ff && (state_ff == ODQ_FINISH), "insert into full store not flagged")

endmodule

// ===== sim/ordered_deque_with_match_remove_unit_test.sv =====
// ---------------------------------------------------------------------------
// ordered_deque_with_match_remove_unit_test
// drives push back/front, remove-all-equal and find words into the unit,
// tracks the store in a queue-based shadow and checks every response word
// in order; both channel sides idle and stall at random
// ---------------------------------------------------------------------------
module ordered_deque_with_match_remove_unit_test
   import odq_pkg::*;
();

   localparam int DEPTH        = 16;
   localparam int RANDOM_WORDS = 1050;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 40;

   typedef struct packed {
      logic       found;
      logic [4:0] removed_count;
      logic [4:0] occupancy;
      logic       overflow;
   } rsp_word_type;

   typedef struct packed {
      opcode_type   op;
      logic [31:0]  value;
      logic         typed;   // use want instead of the shadow prediction
      rsp_word_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   odq_req_if req_chan ();
   odq_rsp_if rsp_chan ();

   ordered_deque_with_match_remove_unit #(
      .CAPACITY (DEPTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   logic [31:0]  shadow_cells[$];
   rsp_word_type pending_rsp_q[$];
   int           error_count = 0;
   int           idle_cycles = 0;
   bit           send_idle_on = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // apply one command to the shadow store and return the response it yields
   function automatic rsp_word_type apply_to_shadow(opcode_type op, logic [31:0] val);
      rsp_word_type r;
      logic [31:0]  kept[$];
      r = '0;
      case (op)
         OP_BACK, OP_FRONT: begin
            if (shadow_cells.size() >= DEPTH) r.overflow = 1'b1;
            else if (op == OP_BACK) shadow_cells.push_back(val);
            else shadow_cells.push_front(val);
         end
         OP_REMOVE: begin
            foreach (shadow_cells[i]) begin
               if (shadow_cells[i] == val) r.removed_count = r.removed_count + 5'd1;
               else kept.push_back(shadow_cells[i]);
            end
            shadow_cells = kept;
         end
         default: begin
            foreach (shadow_cells[i]) begin
               if (shadow_cells[i] == val) r.found = 1'b1;
            end
         end
      endcase
      r.occupancy = 5'(shadow_cells.size());
      return r;
   endfunction

   // valid stays high after acceptance; the next call either replaces the word
   // or drops valid for a gap
   task automatic send_word(opcode_type op, logic [31:0] val, logic typed,
                            rsp_word_type want);
      int           gap;
      rsp_word_type pred;
      gap = send_idle_on ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.opcode <= op;
      req_chan.value  <= val;
      do @(posedge clock); while (!req_chan.ready);
      pred = apply_to_shadow(op, val);
      pending_rsp_q.push_back(typed ? want : pred);
   endtask

   initial begin : stimulus
      stim_row_type dir_rows[$];
      logic [31:0]  pool[4];
      int           pool_n;
      int           ins_pct;
      int           seq_len;
      int           sent;
      opcode_type   op;
      logic [31:0]  val;

      req_chan.valid  <= 1'b0;
      req_chan.opcode <= OP_BACK;
      req_chan.value  <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // empty store, then fill to capacity with extremes and a repeated value
      dir_rows.push_back('{OP_FIND,   32'h0000_0000, 1'b1, '{1'b0, 5'd0, 5'd0, 1'b0}});
      dir_rows.push_back('{OP_REMOVE, 32'h8000_0000, 1'b1, '{1'b0, 5'd0, 5'd0, 1'b0}});
      dir_rows.push_back('{OP_BACK,   32'h7fff_ffff, 1'b1, '{1'b0, 5'd0, 5'd1, 1'b0}});
      dir_rows.push_back('{OP_FRONT,  32'h8000_0000, 1'b0, '0});
      dir_rows.push_back('{OP_BACK,   32'hffff_ffff, 1'b0, '0});
      dir_rows.push_back('{OP_BACK,   32'h0000_0000, 1'b0, '0});
      for (int i = 0; i < 12; i++) begin
         dir_rows.push_back('{(i % 2 == 0) ? OP_FRONT : OP_BACK, 32'd5, 1'b0, '0});
      end
      // full store drops inserts at either end
      dir_rows.push_back('{OP_BACK,   32'd9,         1'b1, '{1'b0, 5'd0, 5'd16, 1'b1}});
      dir_rows.push_back('{OP_FRONT,  32'd9,         1'b1, '{1'b0, 5'd0, 5'd16, 1'b1}});
      dir_rows.push_back('{OP_FIND,   32'h8000_0000, 1'b0, '0});
      dir_rows.push_back('{OP_REMOVE, 32'd5,         1'b0, '0});
      dir_rows.push_back('{OP_FIND,   32'd5,         1'b0, '0});
      dir_rows.push_back('{OP_REMOVE, 32'h7fff_ffff, 1'b0, '0});

      foreach (dir_rows[i]) begin
         send_word(dir_rows[i].op, dir_rows[i].value, dir_rows[i].typed, dir_rows[i].want);
      end

      // random runs over a small pool of values so removes and finds hit often
      sent = 0;
      while (sent < RANDOM_WORDS) begin
         pool_n = $urandom_range(1, 4);
         for (int k = 0; k < 4; k++) begin
            case ($urandom_range(0, 3))
               0: pool[k] = $urandom_range(0, 7);
               1: begin
                  case ($urandom_range(0, 3))
                     0: pool[k] = 32'h8000_0000;
                     1: pool[k] = 32'h7fff_ffff;
                     2: pool[k] = 32'h0000_0000;
                     default: pool[k] = 32'hffff_ffff;
                  endcase
               end
               default: pool[k] = $urandom;
            endcase
         end
         ins_pct      = $urandom_range(20, 85);
         seq_len      = $urandom_range(8, 48);
         send_idle_on = ($urandom_range(0, 3) != 0);
         for (int n = 0; n < seq_len && sent < RANDOM_WORDS; n++) begin
            if ($urandom_range(0, 99) < ins_pct) begin
               op = ($urandom_range(0, 1) != 0) ? OP_BACK : OP_FRONT;
            end else begin
               op = ($urandom_range(0, 1) != 0) ? OP_REMOVE : OP_FIND;
            end
            if ($urandom_range(0, 9) == 0) val = $urandom;
            else val = pool[$urandom_range(0, pool_n - 1)];
            send_word(op, val, 1'b0, '0);
            sent++;
         end
      end
      req_chan.valid <= 1'b0;

      wait (pending_rsp_q.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin : response_side
      int           stall;
      bit           stall_on;
      rsp_word_type got;
      rsp_word_type want;
      rsp_chan.ready <= 1'b0;
      stall_on = 1'b1;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 31) == 0) stall_on = !stall_on;
         stall = stall_on ? $urandom_range(0, 3) : 0;
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         got = {rsp_chan.found, rsp_chan.removed_count, rsp_chan.occupancy, rsp_chan.overflow};
         if (pending_rsp_q.size() == 0) begin
            error_count++;
            if (error_count <= 10) $display("error: response word with none pending: %h", got);
         end else begin
            want = pending_rsp_q.pop_front();
            if (got.found !== want.found || got.removed_count !== want.removed_count ||
                got.occupancy !== want.occupancy || got.overflow !== want.overflow) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("error: found %b/%b removed %0d/%0d occupancy %0d/%0d overflow %b/%b",
                           want.found, got.found, want.removed_count, got.removed_count,
                           want.occupancy, got.occupancy, want.overflow, got.overflow);
               end
            end
         end
      end
   end

   // ends a hung run: no word moved on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
